/* src/byte_stream_tokenizer_assert.svh */
// Assertion macros shared by the tokenizer checkers.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BYTE_STREAM_TOKENIZER_ASSERT_SVH
`define BYTE_STREAM_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

/* src/bst_pkg.sv */
`default_nettype none

package bst_pkg;

  localparam logic [1:0] CLS_SPACE = 2'd0;
  localparam logic [1:0] CLS_WORD  = 2'd1;
  localparam logic [1:0] CLS_QUOTE = 2'd2;
  localparam logic [1:0] CLS_OPER  = 2'd3;

  localparam logic [7:0] CHR_SPACE     = 8'h20;
  localparam logic [7:0] CHR_TAB       = 8'h09;
  localparam logic [7:0] CHR_CR        = 8'h0D;
  localparam logic [7:0] CHR_QUOTE     = 8'h22;
  localparam logic [7:0] CHR_DOT       = 8'h2E;
  localparam logic [7:0] CHR_UNDER     = 8'h5F;
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_HIGH_BIT  = 8'h80;

  localparam int CFG_W = 13;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } bst_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       keep;
    logic       token_start;
    logic [1:0] token_class;
    logic       too_long;
    logic       last_out;
  } bst_out_t;

  // Character class of one byte, C-locale rules for ASCII; bytes with the high bit set count as word bytes.
  function automatic logic [1:0] classify(input logic [7:0] b);
    logic [1:0] c;
    if (b == CHR_SPACE || (b >= CHR_TAB && b <= CHR_CR)) begin
      c = CLS_SPACE;
    end else if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
                 (b >= 8'h41 && b <= 8'h5A) || b == CHR_UNDER ||
                 (b & CHR_HIGH_BIT) != 8'h00) begin
      c = CLS_WORD;
    end else if (b == CHR_QUOTE) begin
      c = CLS_QUOTE;
    end else begin
      c = CLS_OPER;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/byte_stream_tokenizer.sv */
// byte_stream_tokenizer: marks token boundaries in a byte stream.
// An accepted input request has its result registered in the output register, and the
// mode and length update is a single registered pass. Throughput: one byte per cycle
// while the result side does not stall. Reset (rst_n low, synchronous): scanner idle,
// token length zero, no result pending, and the buffer size register returns to 256.
`default_nettype none

module byte_stream_tokenizer
  import bst_pkg::*;
#(
  parameter int MAX_BUFFER_SIZE = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Input request channel.
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire bst_in_t          in_data,
  // Result channel.
  output logic                  out_valid,
  input  wire logic             out_stall,
  output bst_out_t              out_data,
  // Buffer size register write.
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  // The token length saturates at MAX_BUFFER_SIZE, so it needs enough bits to hold it.
  localparam int LEN_W = $clog2(MAX_BUFFER_SIZE + 1);
  // Compare width wide enough for both the register value and the limit.
  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BUFFER_SIZE);

  // Scanner modes.
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_SPACE = 3'd1;
  localparam logic [2:0] MODE_WORD  = 3'd2;
  localparam logic [2:0] MODE_QUOTE = 3'd3;
  localparam logic [2:0] MODE_ESC   = 3'd4;
  localparam logic [2:0] MODE_OPER  = 3'd5;

  // The register value is clamped to the range [2, MAX_BUFFER_SIZE] once, at write time,
  // so the per-byte path only has to compare against a ready-made limit.
  function automatic logic [LEN_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] w;
    logic [CMP_W-1:0] r;
    w = CMP_W'(v);
    if (w < CMP_W'(2)) begin
      r = CMP_W'(2);
    end else if (w > CMP_W'(MAX_BUFFER_SIZE)) begin
      r = CMP_W'(MAX_BUFFER_SIZE);
    end else begin
      r = w;
    end
    return r[LEN_W-1:0];
  endfunction

  localparam logic [LEN_W-1:0] RESET_LIMIT = clamp_size(CFG_W'(256));

  logic [2:0]       mode_r;
  logic [2:0]       mode_nxt;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic [LEN_W-1:0] limit_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  bst_out_t         out_data_r;
  bst_out_t         res;

  logic             accept;
  logic [1:0]       cls;
  logic             cont;
  logic [LEN_W-1:0] len_base;
  logic [LEN_W-1:0] len_inc;

  // The output register parts the two sides: a new request is taken whenever the
  // register is empty or its result leaves in this same cycle.
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cls = classify(in_data.in_byte);

  // Does this byte extend the open token?
  always_comb begin
    unique case (mode_r)
      MODE_SPACE: cont = (cls == CLS_SPACE);
      MODE_WORD:  cont = (cls == CLS_WORD) || (in_data.in_byte == CHR_DOT);
      MODE_OPER:  cont = (cls == CLS_OPER);
      MODE_QUOTE: cont = 1'b1;
      MODE_ESC:   cont = 1'b1;
      default:    cont = 1'b0;
    endcase
  end

  always_comb begin
    res.out_byte    = in_data.in_byte;
    res.keep        = 1'b1;
    res.token_start = 1'b0;
    res.token_class = CLS_SPACE;
    res.too_long    = 1'b0;
    res.last_out    = in_data.end_of_text;
    mode_nxt        = mode_r;
    len_base        = len_r;

    if (!cont) begin
      // A new token opens; its class is the class of its first byte.
      res.token_start = 1'b1;
      res.token_class = cls;
      len_base        = '0;
      unique case (cls)
        CLS_SPACE: mode_nxt = MODE_SPACE;
        CLS_WORD:  mode_nxt = MODE_WORD;
        CLS_QUOTE: mode_nxt = MODE_QUOTE;
        default:   mode_nxt = MODE_OPER;
      endcase
      if (cls == CLS_SPACE) begin
        res.out_byte = CHR_SPACE;
      end
    end else begin
      unique case (mode_r)
        MODE_SPACE: begin
          // Later bytes of a whitespace run are dropped.
          res.token_class = CLS_SPACE;
          res.out_byte    = CHR_SPACE;
          res.keep        = 1'b0;
        end
        MODE_WORD: res.token_class = CLS_WORD;
        MODE_OPER: res.token_class = CLS_OPER;
        MODE_ESC: begin
          // The escaped byte is taken as is, whatever it is.
          res.token_class = CLS_QUOTE;
          mode_nxt        = MODE_QUOTE;
        end
        default: begin
          res.token_class = CLS_QUOTE;
          if (in_data.in_byte == CHR_BACKSLASH) begin
            mode_nxt = MODE_ESC;
          end else if (cls == CLS_QUOTE) begin
            // The closing quote completes the token; the next byte starts a new one.
            mode_nxt = MODE_IDLE;
          end
        end
      endcase
    end

    // Space tokens carry no length; other tokens count with saturation.
    len_inc = (len_base < MAX_LEN) ? len_base + LEN_W'(1) : len_base;
    if (res.token_class != CLS_SPACE) begin
      len_nxt      = len_inc;
      res.too_long = (len_inc >= limit_r);
    end else begin
      len_nxt = '0;
    end

    // The final byte of the text always returns the scanner to idle.
    if (in_data.end_of_text) begin
      mode_nxt = MODE_IDLE;
      len_nxt  = '0;
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      len_r       <= '0;
      limit_r     <= RESET_LIMIT;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        mode_r <= mode_nxt;
        len_r  <= len_nxt;
      end
      if (cfg_valid) begin
        limit_r <= clamp_size(cfg_data);
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

/* src/bst_checker.sv */
`default_nettype none

`include "byte_stream_tokenizer_assert.svh"

module bst_checker
  import bst_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire bst_in_t          in_data,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire bst_out_t         out_data,
  input wire logic             cfg_valid,
  input wire logic             cfg_ready,
  input wire logic [CFG_W-1:0] cfg_data
);

  logic out_accept;
  logic in_accept;
  logic cfg_seen;
  logic start_due_r;

  assign out_accept = out_valid & ~out_stall;
  assign in_accept  = in_valid & ~in_stall;
  assign cfg_seen   = cfg_valid & cfg_ready & (cfg_data != '0 || cfg_data == '0);

  // After the end of the text, or after reset, the next result must open a token.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_due_r <= 1'b1;
    end else if (out_accept) begin
      start_due_r <= out_data.last_out;
    end
  end

  `BST_ASSERT_NXT(a_one_cycle_latency, in_accept, out_valid)
  `BST_ASSERT_IMP(a_start_after_end, out_valid && start_due_r && !cfg_seen, out_data.token_start)
  `BST_ASSERT_IMP(a_dropped_is_space,
                  out_valid && !out_data.keep,
                  out_data.token_class == CLS_SPACE && !out_data.token_start)
  `BST_ASSERT_IMP(a_space_token_form,
                  out_valid && out_data.token_class == CLS_SPACE,
                  out_data.out_byte == CHR_SPACE && !out_data.too_long)
  `BST_ASSERT_NXT(a_stalled_result_holds, out_valid && out_stall,
                  out_valid && $stable(out_data))

endmodule

bind byte_stream_tokenizer bst_checker u_bst_checker (.*);

`default_nettype wire

/* tb/tb.sv */
package tokenizer_tb_pkg;
  import bst_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_SPACE,
    SCAN_WORD,
    SCAN_QUOTE,
    SCAN_ESC,
    SCAN_OPER
  } scan_mode_e;

  // Character class of one text byte under C-locale rules for ASCII; high-bit bytes count as word bytes.
  function automatic logic [1:0] byte_kind(input logic [7:0] b);
    if (b == CHR_SPACE || (b >= CHR_TAB && b <= CHR_CR)) begin
      return CLS_SPACE;
    end
    if (b[7] || b == CHR_UNDER || (b >= "0" && b <= "9") ||
        (b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) begin
      return CLS_WORD;
    end
    if (b == CHR_QUOTE) begin
      return CLS_QUOTE;
    end
    return CLS_OPER;
  endfunction

  class token_scoreboard;
    int unsigned max_len;
    scan_mode_e mode;
    int unsigned run_len;
    logic [CFG_W-1:0] size_reg;
    bst_out_t owed_q[$];
    int errors;
    int seen;

    function new(int unsigned max_len_i);
      max_len = max_len_i;
      mode = SCAN_IDLE;
      run_len = 0;
      size_reg = 13'd256;
      errors = 0;
      seen = 0;
    endfunction

    function void set_size(logic [CFG_W-1:0] v);
      size_reg = v;
    endfunction

    // Buffer size as the block applies it, clamped to the legal range.
    function int unsigned eff_size();
      int unsigned s;
      s = size_reg;
      if (s < 2) s = 2;
      if (s > max_len) s = max_len;
      return s;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("[%0t] mismatch on result %0d: %s got %0h want %0h", $time, seen, what, got,
               want);
    endtask

    // Works out the token marking of one accepted byte and advances the scanner.
    function bst_out_t tokenize(bst_in_t req);
      logic [1:0] cls;
      logic cont;
      bst_out_t r;
      cls = byte_kind(req.in_byte);
      r.out_byte = req.in_byte;
      r.keep = 1'b1;
      r.token_start = 1'b0;
      r.token_class = CLS_SPACE;
      r.too_long = 1'b0;
      r.last_out = req.end_of_text;
      case (mode)
        SCAN_SPACE: cont = (cls == CLS_SPACE);
        SCAN_WORD: cont = (cls == CLS_WORD) || (req.in_byte == CHR_DOT);
        SCAN_OPER: cont = (cls == CLS_OPER);
        SCAN_QUOTE, SCAN_ESC: cont = 1'b1;
        default: cont = 1'b0;
      endcase
      if (!cont) begin
        r.token_start = 1'b1;
        run_len = 0;
        r.token_class = cls;
        case (cls)
          CLS_SPACE: mode = SCAN_SPACE;
          CLS_WORD: mode = SCAN_WORD;
          CLS_QUOTE: mode = SCAN_QUOTE;
          default: mode = SCAN_OPER;
        endcase
      end else begin
        case (mode)
          SCAN_SPACE: begin
            r.token_class = CLS_SPACE;
            r.keep = 1'b0;
          end
          SCAN_WORD: r.token_class = CLS_WORD;
          SCAN_OPER: r.token_class = CLS_OPER;
          SCAN_ESC: begin
            r.token_class = CLS_QUOTE;
            mode = SCAN_QUOTE;
          end
          default: begin
            r.token_class = CLS_QUOTE;
            if (req.in_byte == CHR_BACKSLASH) begin
              mode = SCAN_ESC;
            end else if (cls == CLS_QUOTE) begin
              mode = SCAN_IDLE;
            end
          end
        endcase
      end
      if (r.token_class == CLS_SPACE) begin
        r.out_byte = CHR_SPACE;
        run_len = 0;
      end else begin
        if (run_len < max_len) run_len++;
        r.too_long = (run_len >= eff_size());
      end
      if (req.end_of_text) begin
        mode = SCAN_IDLE;
        run_len = 0;
      end
      return r;
    endfunction

    function void note_request(bst_in_t req);
      owed_q.push_back(tokenize(req));
    endfunction

    task cmp_field(string name, int got, int want);
      if (got != want) report(name, got, want);
    endtask

    task check_result(bst_out_t got);
      bst_out_t want;
      seen++;
      if (owed_q.size() == 0) begin
        report("unexpected result", got, 0);
        return;
      end
      want = owed_q.pop_front();
      cmp_field("out_byte", got.out_byte, want.out_byte);
      cmp_field("keep", got.keep, want.keep);
      cmp_field("token_start", got.token_start, want.token_start);
      cmp_field("token_class", got.token_class, want.token_class);
      cmp_field("too_long", got.too_long, want.too_long);
      cmp_field("last_out", got.last_out, want.last_out);
    endtask

    task close_out();
      if (owed_q.size() != 0) report("results never delivered", owed_q.size(), 0);
    endtask
  endclass

endpackage

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bst_pkg::*;
  import tokenizer_tb_pkg::*;

  localparam int unsigned MAX_BUF = 4096;

  // Every input of the block holds a known value from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  bst_in_t in_data = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_stall;
  logic out_valid;
  bst_out_t out_data;
  logic cfg_ready;

  // When set, both sides run back to back with no idle cycles, so that the
  // block also sees stretches of full-rate traffic.
  bit no_idle = 1'b0;

  token_scoreboard sb;

  byte_stream_tokenizer #(
    .MAX_BUFFER_SIZE(MAX_BUF)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // All inputs change with nonblocking assignments right after a rising
  // edge, and all outputs are read right after the edge, before the block's
  // own updates land, so every sample is the value that was present at the edge.

  // Sends one text byte as an input request. A random gap comes first; when
  // there is no gap, valid simply stays high for the next request.
  task automatic send_request(input bst_in_t req);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eot);
    bst_in_t req;
    req.in_byte = b;
    req.end_of_text = eot;
    send_request(req);
  endtask

  // Waits until every request has produced its result, then lets a little
  // margin pass, so the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes the buffer size register; only called while the block is idle.
  task automatic write_size(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_size(v);
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 4))
      0: return 8'("a" + $urandom_range(0, 25));
      1: return 8'("A" + $urandom_range(0, 25));
      2: return 8'("0" + $urandom_range(0, 9));
      3: return CHR_UNDER;
      default: return CHR_HIGH_BIT | 8'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [7:0] space_char();
    if ($urandom_range(0, 1) == 0) return CHR_SPACE;
    return 8'(CHR_TAB + $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] oper_char();
    logic [7:0] b;
    b = 8'($urandom_range(1, 127));
    while (byte_kind(b) != CLS_OPER) b = 8'($urandom_range(1, 127));
    return b;
  endfunction

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(1, 255));
  endfunction

  // Token lengths: mostly short, sometimes up to a moderate size, and now and then,
  // for a buffer size of at most 300, right around it so the too-long flag toggles.
  function automatic int pick_len(input int unsigned eff);
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 6);
    if (r < 19) return $urandom_range(1, (eff + 2 < 40) ? eff + 2 : 40);
    if (eff <= 300) return $urandom_range(eff - 1, eff + 2);
    return $urandom_range(1, 12);
  endfunction

  // Random text built mostly from well-formed tokens with random content,
  // mixed with raw noise. The text ends now and then, including in the
  // middle of a token or right after a backslash inside a quoted string.
  task automatic send_text(input int n_items);
    int sent;
    int len;
    int kind;
    int tail;
    logic eot_last;
    logic [7:0] b;
    logic [7:0] tok[$];
    sent = 0;
    while (sent < n_items) begin
      no_idle = ($urandom_range(0, 5) == 0);
      tok.delete();
      len = pick_len(sb.eff_size());
      kind = $urandom_range(0, 9);
      eot_last = ($urandom_range(0, 7) == 0);
      if (kind <= 2) begin
        tok.push_back(word_char());
        for (int i = 1; i < len; i++) begin
          tok.push_back(($urandom_range(0, 9) == 0) ? CHR_DOT : word_char());
        end
      end else if (kind <= 4) begin
        for (int i = 0; i < ((len > 5) ? 5 : len); i++) tok.push_back(space_char());
      end else if (kind <= 6) begin
        for (int i = 0; i < len; i++) tok.push_back(oper_char());
      end else if (kind <= 8) begin
        tok.push_back(CHR_QUOTE);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 6) == 0) begin
            tok.push_back(CHR_BACKSLASH);
            tok.push_back(any_char());
          end else begin
            b = any_char();
            while (b == CHR_QUOTE || b == CHR_BACKSLASH) b = any_char();
            tok.push_back(b);
          end
        end
        tail = $urandom_range(0, 9);
        if (tail < 7) begin
          tok.push_back(CHR_QUOTE);
        end else if (tail == 7) begin
          // A backslash as the final byte escapes nothing.
          tok.push_back(CHR_BACKSLASH);
          eot_last = 1'b1;
        end
      end else begin
        for (int i = 0; i < len; i++) tok.push_back(any_char());
      end
      foreach (tok[i]) begin
        send_byte(tok[i], eot_last && (i == tok.size() - 1));
      end
      sent += tok.size();
    end
    no_idle = 1'b0;
  endtask

  // Result side: stalls for a random number of cycles before each result,
  // then takes the next one and checks it.
  initial begin
    int hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 16);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_data);
    end
  end

  initial begin
    int spin;
    logic [8:0] directed [0:21];
    logic [CFG_W-1:0] sizes [$];
    // Directed text: whitespace run with dropped tail, a word that takes a
    // dot and high-bit bytes, an operator run, a quoted string with an
    // escaped quote, a closing quote followed at once by a new quote, a
    // backslash as the final byte, and a dot that opens an operator token.
    directed = '{
      {CHR_SPACE, 1'b0}, {CHR_TAB, 1'b0}, {CHR_CR, 1'b0}, {8'h0A, 1'b0},
      {"A", 1'b0}, {"z", 1'b0}, {"9", 1'b0}, {CHR_UNDER, 1'b0}, {CHR_DOT, 1'b0},
      {CHR_HIGH_BIT, 1'b0}, {8'hFF, 1'b0},
      {8'h0E, 1'b0}, {8'h08, 1'b0}, {8'h7F, 1'b0},
      {CHR_QUOTE, 1'b0}, {CHR_BACKSLASH, 1'b0}, {CHR_QUOTE, 1'b0}, {CHR_QUOTE, 1'b0},
      {CHR_QUOTE, 1'b0}, {CHR_BACKSLASH, 1'b1},
      {CHR_DOT, 1'b0}, {"0", 1'b1}
    };
    sb = new(MAX_BUF);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first phase runs with the buffer size left at its reset value.
    foreach (directed[i]) send_request(bst_in_t'(directed[i]));
    send_text(110);

    // Sizes below two act as two and sizes above the maximum act as the
    // maximum; the register's all-zero and all-one values are both written.
    sizes = '{13'd2, 13'd0, 13'd1, 13'd3, 13'd8191, 13'd4096, 13'd4097, 13'd7,
              13'($urandom_range(2, 64)), 13'($urandom_range(0, 8191)), 13'd256};
    foreach (sizes[k]) begin
      settle();
      write_size(sizes[k]);
      send_text(130);
    end

    // Drain: wait for every owed result, then a few cycles for strays.
    in_valid <= 1'b0;
    for (spin = 0; spin < 2000 && sb.pending() != 0; spin++) @(posedge clk);
    repeat (4) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // The slowest legal run stays well within this time limit; reaching it
  // declares the block hung.
  initial begin
    #(12_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/bst_pkg.sv
src/byte_stream_tokenizer.sv
src/bst_checker.sv
tb/tb.sv
